// File: rtl/core/bfdp_pkg.sv
// Package for the bfloat16 dual lane dot product.
// Holds the stage control type and the bfloat16 multiply and add functions.
package bfdp_pkg;

   localparam logic [15:0] BF_NAN = 16'h7F81;
   localparam logic [15:0] BF_INF = 16'h7F80;
   localparam logic [10:0] BIAS   = 11'd127;

   typedef struct packed {
      logic pair_valid;
      logic last;
   } ctl_type;

   function automatic logic [15:0] bf_pack(input logic s, input logic signed [10:0] e,
                                           input logic [7:0] m);
      logic [15:0] r;
      if (e <= 0) r = {s, 15'd0};
      else if (e >= 255) r = {s, BF_INF[14:0]};
      else r = {s, e[7:0], m[6:0]};
      return r;
   endfunction

   function automatic logic [15:0] bf_mul(input logic [15:0] x, input logic [15:0] y);
      logic              s;
      logic [7:0]        ex;
      logic [7:0]        ey;
      logic [15:0]       p;
      logic [7:0]        m;
      logic signed [10:0] e;
      logic [15:0]       r;
      s  = x[15] ^ y[15];
      ex = x[14:7];
      ey = y[14:7];
      p  = {1'b1, x[6:0]} * {1'b1, y[6:0]};
      e  = $signed({3'd0, ex} + {3'd0, ey} - BIAS);
      if (p[15]) begin
         m = p[15:8];
         e = e + 11'sd1;
      end else begin
         m = p[14:7];
      end
      if ((ex == 8'hFF && x[6:0] != 7'd0) || (ey == 8'hFF && y[6:0] != 7'd0)) r = BF_NAN;
      else if (ex == 8'hFF || ey == 8'hFF) r = (ex == 8'd0 || ey == 8'd0) ? BF_NAN :
                                              {s, BF_INF[14:0]};
      else if (ex == 8'd0 || ey == 8'd0) r = {s, 15'd0};
      else r = bf_pack(s, e, m);
      return r;
   endfunction

   function automatic logic [15:0] bf_add(input logic [15:0] x, input logic [15:0] y);
      logic [7:0]         ex;
      logic [7:0]         ey;
      logic [7:0]         ma;
      logic [7:0]         mb;
      logic [7:0]         d;
      logic [8:0]         sum;
      logic [9:0]         rnd;
      logic               s;
      logic signed [10:0] e;
      logic [2:0]         pos;
      logic [7:0]         m;
      logic [15:0]        r;
      ex = x[14:7];
      ey = y[14:7];
      ma = {1'b1, x[6:0]};
      mb = {1'b1, y[6:0]};
      if (ex >= ey) begin
         d  = ex - ey;
         mb = (d >= 8'd8) ? 8'd0 : (mb >> d[2:0]);
         e  = $signed({3'd0, ex});
      end else begin
         d  = ey - ex;
         ma = (d >= 8'd8) ? 8'd0 : (ma >> d[2:0]);
         e  = $signed({3'd0, ey});
      end
      if (x[15] == y[15]) begin
         sum = {1'b0, ma} + {1'b0, mb};
         s   = x[15];
      end else if (ma >= mb) begin
         sum = {1'b0, ma - mb};
         s   = x[15];
      end else begin
         sum = {1'b0, mb - ma};
         s   = y[15];
      end
      pos = 3'd0;
      for (int i = 0; i < 8; i++) begin
         if (sum[i]) pos = 3'(i);
      end
      rnd = {1'b0, sum} + 10'd1;
      if (sum[8]) begin
         if (rnd[9]) begin
            m = 8'h80;
            e = e + 11'sd2;
         end else begin
            m = rnd[8:1];
            e = e + 11'sd1;
         end
      end else begin
         m = sum[7:0] << (3'd7 - pos);
         e = e - $signed({8'd0, 3'd7 - pos});
      end
      if ((ex == 8'hFF && x[6:0] != 7'd0) || (ey == 8'hFF && y[6:0] != 7'd0)) r = BF_NAN;
      else if (ex == 8'hFF && ey == 8'hFF) r = (x[15] != y[15]) ? BF_NAN : x;
      else if (ex == 8'hFF) r = x;
      else if (ey == 8'hFF) r = y;
      else if (ex == 8'd0 && ey == 8'd0) r = {x[15] & y[15], 15'd0};
      else if (ex == 8'd0) r = y;
      else if (ey == 8'd0) r = x;
      else if (sum == 9'd0) r = 16'd0;
      else r = bf_pack(s, e, m);
      return r;
   endfunction

endpackage

// File: rtl/core/bfdp_if.sv
// Request and result channel interfaces of the bfloat16 dot product.
// Valid/ready handshake; no package dependency.
interface bfdp_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] a_first;
   logic [15:0] b_first;
   logic [15:0] a_second;
   logic [15:0] b_second;
   logic        pair_valid;
   logic        last;
   modport source (output valid, a_first, b_first, a_second, b_second, pair_valid, last,
                   input ready);
   modport sink   (input valid, a_first, b_first, a_second, b_second, pair_valid, last,
                   output ready);
endinterface

interface bfdp_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] sum;
   modport source (output valid, sum, input ready);
   modport sink   (input valid, sum, output ready);
endinterface

// File: rtl/core/bfdp_lane.sv
// One multiplier lane: registered bfloat16 product of an element pair.
// Uses bf_mul from bfdp_pkg.
module bfdp_lane (
   input  logic        clock,
   input  logic        enable,
   input  logic [15:0] a,
   input  logic [15:0] b,
   output logic [15:0] product
);
   import bfdp_pkg::*;

   logic [15:0] product_ff;
   logic [15:0] product_in;

   assign product_in = bf_mul(a, b);

   always_ff @(posedge clock) begin
      if (enable) product_ff <= product_in;
   end

   assign product = product_ff;
endmodule

// File: rtl/core/bfdp_merge.sv
// Merge stage: adds the two lane products when both pairs are present.
// Uses bf_add and ctl_type from bfdp_pkg.
module bfdp_merge (
   input  logic              clock,
   input  logic              enable,
   input  bfdp_pkg::ctl_type ctl,
   input  logic [15:0]       product_first,
   input  logic [15:0]       product_second,
   output logic [15:0]       term
);
   import bfdp_pkg::*;

   logic [15:0] term_ff;
   logic [15:0] term_in;

   assign term_in = ctl.pair_valid ? bf_add(product_first, product_second) : product_first;

   always_ff @(posedge clock) begin
      if (enable) term_ff <= term_in;
   end

   assign term = term_ff;
endmodule

// File: rtl/core/bf16_dual_lane_dot_product.sv
// Top level of the bfloat16 dual lane dot product accumulator.
// Depends on bfdp_pkg, bfdp_if, bfdp_lane and bfdp_merge.
//
// Each request on req_bus carries one or two bfloat16 element pairs; two
// multiplier lanes form the products, a merge stage adds them when
// pair_valid is set, and an accumulator adds the term into the
// running sum. A request with last set delivers the sum on rsp_bus and
// clears the accumulator to +0.
// Throughput: one request per cycle while the pipeline is not stalled.
// A last request's sum passes the lane register, the merge register and
// the result register before it is valid on rsp_bus.
// Reset clears all stage valids, the result valid and the accumulator.
// When rsp_bus stalls, requests keep flowing; only a last request that
// reaches the accumulator while a result still waits holds the pipeline,
// and req_bus.ready drops until the waiting result is taken.
module bf16_dual_lane_dot_product (
   input  logic       clock,
   input  logic       reset,
   bfdp_req_if.sink   req_bus,
   bfdp_rsp_if.source rsp_bus
);
   import bfdp_pkg::*;

   logic        s1_valid_ff;
   ctl_type     s1_ctl_ff;
   logic        s2_valid_ff;
   logic        s2_last_ff;
   logic [15:0] acc_ff;
   logic [15:0] acc_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [15:0] rsp_sum_ff;
   logic [15:0] prod_first;
   logic [15:0] prod_second;
   logic [15:0] term;
   logic        stall;
   logic        advance;
   ctl_type     req_ctl;

   assign stall   = s2_valid_ff && s2_last_ff && rsp_valid_ff && !rsp_bus.ready;
   assign advance = !stall;
   assign req_bus.ready = advance;
   assign req_ctl = '{pair_valid: req_bus.pair_valid, last: req_bus.last};

   bfdp_lane u_lane_first (
      .clock(clock), .enable(advance), .a(req_bus.a_first), .b(req_bus.b_first),
      .product(prod_first)
   );

   bfdp_lane u_lane_second (
      .clock(clock), .enable(advance), .a(req_bus.a_second), .b(req_bus.b_second),
      .product(prod_second)
   );

   bfdp_merge u_merge (
      .clock(clock), .enable(advance), .ctl(s1_ctl_ff), .product_first(prod_first),
      .product_second(prod_second), .term(term)
   );

   assign acc_in = bf_add(acc_ff, term);

   assign rsp_valid_in = (advance && s2_valid_ff && s2_last_ff) ||
                         (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s2_last_ff   <= 1'b0;
         acc_ff       <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            s1_valid_ff <= req_bus.valid;
            s1_ctl_ff   <= req_ctl;
            s2_valid_ff <= s1_valid_ff;
            s2_last_ff  <= s1_ctl_ff.last;
            if (s2_valid_ff) begin
               if (s2_last_ff) begin
                  acc_ff     <= 16'd0;
                  rsp_sum_ff <= acc_in;
               end else begin
                  acc_ff <= acc_in;
               end
            end
         end
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.sum   = rsp_sum_ff;

   a_acc_cleared: assert property (@(posedge clock) disable iff (reset)
      (advance && s2_valid_ff && s2_last_ff) |=> (acc_ff == 16'd0))
      else $error("accumulator not cleared after final request");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s2_valid_ff && s2_last_ff))
      else $error("result raised without a final request");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> (rsp_valid_ff && s2_last_ff))
      else $error("request stalled without a waiting result");

endmodule

// File: tb/sv/tb.sv
// Testbench for bf16_dual_lane_dot_product: drives dot-product requests over
// bfdp_req_if and checks each sum on bfdp_rsp_if against a local bfloat16 model.
// Depends on bfdp_if and the top level RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [15:0] QNAN  = 16'h7F81;
   localparam logic [15:0] PINF  = 16'h7F80;
   localparam int          STALL_LIMIT = 4000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bfdp_req_if req_bus();
   bfdp_rsp_if rsp_bus();

   bf16_dual_lane_dot_product u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   logic [15:0] running_sum;
   logic [15:0] sum_queue[$];
   int          errors = 0;
   int          sums_seen = 0;
   int          reqs_sent = 0;
   int          idle_cycles = 0;
   bit          send_gaps = 1'b1;
   bit          take_gaps = 1'b1;

   function automatic logic [15:0] fp_pack(logic s, int e, logic [7:0] m);
      if (e <= 0) return {s, 15'd0};
      if (e >= 255) return {s, PINF[14:0]};
      return {s, e[7:0], m[6:0]};
   endfunction

   function automatic bit is_nan(logic [15:0] v);
      return v[14:7] == 8'hFF && v[6:0] != 7'd0;
   endfunction

   function automatic logic [15:0] fp_mul(logic [15:0] x, logic [15:0] y);
      logic        s;
      int          e;
      logic [15:0] p;
      s = x[15] ^ y[15];
      if (is_nan(x) || is_nan(y)) return QNAN;
      if (x[14:7] == 8'hFF || y[14:7] == 8'hFF) begin
         if (x[14:7] == 0 || y[14:7] == 0) return QNAN;
         return {s, PINF[14:0]};
      end
      if (x[14:7] == 0 || y[14:7] == 0) return {s, 15'd0};
      p = 16'({1'b1, x[6:0]}) * 16'({1'b1, y[6:0]});
      e = int'(x[14:7]) + int'(y[14:7]) - 127;
      if (p[15]) return fp_pack(s, e + 1, p[15:8]);
      return fp_pack(s, e, p[14:7]);
   endfunction

   function automatic logic [15:0] fp_add(logic [15:0] x, logic [15:0] y);
      int   ex, ey, e, d;
      int   ma, mb, acc;
      logic s;
      ex = x[14:7];
      ey = y[14:7];
      if (is_nan(x) || is_nan(y)) return QNAN;
      if (ex == 255 && ey == 255) return (x[15] != y[15]) ? QNAN : x;
      if (ex == 255) return x;
      if (ey == 255) return y;
      if (ex == 0 && ey == 0) return {x[15] & y[15], 15'd0};
      if (ex == 0) return y;
      if (ey == 0) return x;
      ma = {1'b1, x[6:0]};
      mb = {1'b1, y[6:0]};
      if (ex >= ey) begin
         d  = ex - ey;
         mb = (d >= 8) ? 0 : mb >> d;
         e  = ex;
      end else begin
         d  = ey - ex;
         ma = (d >= 8) ? 0 : ma >> d;
         e  = ey;
      end
      if (x[15] == y[15]) begin
         acc = ma + mb;
         s   = x[15];
      end else if (ma >= mb) begin
         acc = ma - mb;
         s   = x[15];
      end else begin
         acc = mb - ma;
         s   = y[15];
      end
      if (acc == 0) return 16'd0;
      if (acc >= 256) begin
         acc = (acc + 1) >> 1;
         e++;
         if (acc >= 256) begin
            acc = 128;
            e++;
         end
      end else begin
         while ((acc & 128) == 0) begin
            acc = acc << 1;
            e--;
         end
      end
      return fp_pack(s, e, acc[7:0]);
   endfunction

   // advance the running sum and queue the finished dot product
   task automatic model_request(logic [15:0] a0, b0, a1, b1, logic pv, lst);
      logic [15:0] term;
      term = fp_mul(a0, b0);
      if (pv) term = fp_add(term, fp_mul(a1, b1));
      running_sum = fp_add(running_sum, term);
      if (lst) begin
         sum_queue.push_back(running_sum);
         running_sum = 16'd0;
      end
   endtask

   // hold valid between back-to-back requests; drop it only for gaps and drains
   task automatic send_request(logic [15:0] a0, b0, a1, b1, logic pv, lst);
      while (send_gaps && $urandom_range(99) < 37) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.a_first    <= a0;
      req_bus.b_first    <= b0;
      req_bus.a_second   <= a1;
      req_bus.b_second   <= b1;
      req_bus.pair_valid <= pv;
      req_bus.last       <= lst;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      model_request(a0, b0, a1, b1, pv, lst);
      reqs_sent++;
   endtask

   function automatic logic [15:0] rand_value();
      logic [15:0] v;
      int          pick;
      v    = 16'($urandom);
      pick = $urandom_range(99);
      if (pick < 65) v[14:7] = 8'($urandom_range(112, 142));
      else if (pick < 70) v[14:7] = 8'h00;
      else if (pick < 74) v[14:7] = 8'hFF;
      else if (pick < 76) v[6:0] = 7'd0;
      return v;
   endfunction

   task automatic test_directed();
      logic [15:0] specials[12] = '{16'h0000, 16'h8000, 16'h3F80, 16'hBF80, 16'h7F80,
                                    16'hFF80, 16'h7F81, 16'h0001, 16'h7F7F, 16'h0080,
                                    16'hFFFF, 16'h3FFF};
      foreach (specials[i])
         send_request(specials[i], specials[(i * 5 + 3) % 12], specials[(i + 7) % 12],
                      specials[(i * 3) % 12], i[0], 1'b1);
      send_request(16'h3F80, 16'h3F80, 16'hBF80, 16'h3F80, 1'b1, 1'b1);   // cancellation
      send_request(16'h3FFF, 16'h3F80, 16'h3FFF, 16'h3F80, 1'b1, 1'b1);   // mantissa sum carry
      send_request(16'h7F00, 16'h4000, 16'h7F00, 16'h4000, 1'b1, 1'b1);   // overflow
      send_request(16'h0100, 16'h0100, 16'h0000, 16'h0000, 1'b0, 1'b1);   // underflow
      send_request(16'h7F80, 16'h3F80, 16'hFF80, 16'h3F80, 1'b1, 1'b1);   // inf minus inf
      send_request(16'h3F80, 16'h4000, 16'h0000, 16'h0000, 1'b0, 1'b0);
      send_request(16'h3F80, 16'h3C00, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0);   // small shift loss
      send_request(16'h8000, 16'h3F80, 16'h8000, 16'h3F80, 1'b1, 1'b1);
   endtask

   task automatic test_random(int count);
      int left;
      int len;
      left = count;
      while (left > 0) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
         for (int k = 0; k < len && left > 0; k++, left--)
            send_request(rand_value(), rand_value(), rand_value(), rand_value(),
                         1'($urandom), k == len - 1 || left == 1);
      end
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sum_queue.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            sums_seen++;
            if (sum_queue.size() == 0) begin
               $error("unexpected sum %h", rsp_bus.sum);
               errors++;
            end else if (sum_queue[0] !== rsp_bus.sum) begin
               $error("sum: expected %h actual %h", sum_queue[0], rsp_bus.sum);
               errors++;
               void'(sum_queue.pop_front());
            end else begin
               void'(sum_queue.pop_front());
            end
         end
         rsp_bus.ready <= !take_gaps || $urandom_range(99) >= 37;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      req_bus.valid      <= 1'b0;
      req_bus.a_first    <= 16'd0;
      req_bus.b_first    <= 16'd0;
      req_bus.a_second   <= 16'd0;
      req_bus.b_second   <= 16'd0;
      req_bus.pair_valid <= 1'b0;
      req_bus.last       <= 1'b0;
      running_sum = 16'd0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      drain();
      test_random(250);
      send_gaps = 1'b0;
      take_gaps = 1'b0;
      test_random(120);
      send_gaps = 1'b1;
      take_gaps = 1'b1;
      drain();
      test_random(230);
      drain();
      repeat (20) @(posedge clock);
      $display("tb: %0d requests sent, %0d dot products checked, specials and random",
               reqs_sent, sums_seen);
      if (errors == 0 && sum_queue.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule

// File: bf16_dual_lane_dot_product.f
rtl/core/bfdp_pkg.sv
rtl/core/bfdp_if.sv
rtl/core/bfdp_lane.sv
rtl/core/bfdp_merge.sv
rtl/core/bf16_dual_lane_dot_product.sv
tb/sv/tb.sv
